// File: rtl/core/ttsi_pkg.sv
// Shared types, constants and character decode for the text-to-integer core.
// No dependencies; imported by every module under rtl/core.
package ttsi_pkg;

    // Datapath sizing
    localparam int VALUE_WIDTH     = 64;
    localparam int POSITION_WIDTH  = 12;
    localparam int RADIX_WIDTH     = 6;
    localparam int CHAR_WIDTH      = 8;
    localparam int DIGIT_WIDTH     = 6;
    localparam int OUT_VALUE_WIDTH = 64;
    localparam int STATUS_WIDTH    = 2;
    localparam int OFFSET_WIDTH    = 12;
    localparam int S_TDATA_WIDTH   = 8;
    localparam int M_TDATA_WIDTH   = 80;
    localparam int M_FIELD_WIDTH   = OUT_VALUE_WIDTH + STATUS_WIDTH + OFFSET_WIDTH;
    localparam int M_PAD_WIDTH     = M_TDATA_WIDTH - M_FIELD_WIDTH;
    // Multiply-add result: accumulator times a base below 64, plus a digit
    localparam int PROD_WIDTH      = VALUE_WIDTH + RADIX_WIDTH + 1;

    localparam logic [VALUE_WIDTH-1:0]    VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [POSITION_WIDTH-1:0] POS_MAX   = {POSITION_WIDTH{1'b1}};

    // Bases
    localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = RADIX_WIDTH'(10);
    localparam logic [RADIX_WIDTH-1:0] BASE_AUTO   = RADIX_WIDTH'(0);
    localparam logic [RADIX_WIDTH-1:0] BASE_MIN    = RADIX_WIDTH'(2);
    localparam logic [RADIX_WIDTH-1:0] BASE_OCT    = RADIX_WIDTH'(8);
    localparam logic [RADIX_WIDTH-1:0] BASE_DEC    = RADIX_WIDTH'(10);
    localparam logic [RADIX_WIDTH-1:0] BASE_HEX    = RADIX_WIDTH'(16);
    localparam logic [RADIX_WIDTH-1:0] BASE_MAX    = RADIX_WIDTH'(36);

    // Digit code for a byte that is no digit in any base
    localparam logic [DIGIT_WIDTH-1:0] DIGIT_NONE  = {DIGIT_WIDTH{1'b1}};

    // Character codes
    localparam logic [CHAR_WIDTH-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_WIDTH-1:0] ALPHA_BIAS = 8'd10;

    // Result status codes
    localparam logic [STATUS_WIDTH-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_RANGE   = 2'd2;

    // Digit progress of the string being parsed
    typedef enum logic [1:0] {
        DS_NONE = 2'd0,
        DS_OK   = 2'd1,
        DS_OVER = 2'd2
    } digit_status_t;

    // One input beat after the input register
    typedef struct packed {
        logic [CHAR_WIDTH-1:0] char_code;
        logic                  last;
    } ttsi_beat_t;

    // Parse state handed to the result stage on the final byte
    typedef struct packed {
        logic                      negative;
        logic [VALUE_WIDTH-1:0]    accum;
        digit_status_t             dstat;
        logic [POSITION_WIDTH-1:0] end_pos;
    } ttsi_final_t;

    // Map a byte to its digit value 0..35, or DIGIT_NONE
    function automatic logic [DIGIT_WIDTH-1:0] char_digit(input logic [CHAR_WIDTH-1:0] c);
        logic [DIGIT_WIDTH-1:0] d;
        d = DIGIT_NONE;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = DIGIT_WIDTH'(c - CH_ZERO);
        end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            d = DIGIT_WIDTH'(c - CH_UPPER_A + ALPHA_BIAS);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            d = DIGIT_WIDTH'(c - CH_LOWER_A + ALPHA_BIAS);
        end
        return d;
    endfunction

    // Blank characters: space, tab, LF, VT, FF, CR
    function automatic logic char_is_space(input logic [CHAR_WIDTH-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

// File: rtl/core/text_to_signed_integer_core.sv
// Top level of the streaming text-to-signed-integer converter.
// Instantiates ttsi_in_reg, ttsi_parser and ttsi_result; uses ttsi_pkg.
//
// Usage:
//   The slave stream carries a string one byte per beat (s_tdata[7:0]),
//   with s_tlast on the final byte. Blanks are skipped, an optional sign is
//   read, a 0x/0X or leading-zero prefix picks the base when allowed, and
//   digits are accumulated. One result beat follows each string on the
//   master stream: value, status (ok, invalid, out of range) and the byte
//   count through the last digit. Overflow saturates the value.
//   The cfg channel writes the 6-bit radix (0 auto, 2..36 fixed), always ready;
//   write only between strings (not enforced by the block). Reset radix is 10.
// Throughput and result path:
//   One byte per cycle, sustained, unless a final byte waits on a full
//   result stage. The per-byte multiply-add and range compare on the
//   accumulator form the feedback loop that sets this. Once its final byte
//   is accepted, a result passes the input, result hold and output registers.
// Reset and stalls:
//   Reset empties all stages, clears the parse and restores radix 10.
//   While m_tready is low the result and one more held result stay put;
//   non-final bytes keep flowing, and a further final byte waits.
module text_to_signed_integer_core
    import ttsi_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_TDATA_WIDTH-1:0] s_tdata,   // [7:0] char_code
    input  logic                     s_tlast,   // last
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDATA_WIDTH-1:0] m_tdata,   // [63:0] value, [65:64] status,
                                                // [77:66] end_offset, [79:78] zero
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [RADIX_WIDTH-1:0]   cfg_data   // [5:0] radix
);

    logic                   radix_wr;
    logic [RADIX_WIDTH-1:0] radix_val_reg;
    logic [RADIX_WIDTH-1:0] radix_val_next;
    logic                   in_valid;
    ttsi_beat_t             in_beat;
    logic                   in_take;
    logic                   fin_valid;
    logic                   fin_ready;
    ttsi_final_t            fin_data;

    // Radix register, written on each configuration beat
    assign cfg_ready      = 1'b1;
    assign radix_wr       = cfg_valid && cfg_ready;
    assign radix_val_next = radix_wr ? cfg_data : radix_val_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_val_reg <= RADIX_RESET;
        end else begin
            radix_val_reg <= radix_val_next;
        end
    end

    ttsi_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .in_valid (in_valid),
        .in_beat  (in_beat),
        .in_take  (in_take)
    );

    ttsi_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .radix     (radix_val_reg),
        .in_valid  (in_valid),
        .in_beat   (in_beat),
        .in_take   (in_take),
        .fin_ready (fin_ready),
        .fin_valid (fin_valid),
        .fin_data  (fin_data)
    );

    ttsi_result u_result (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fin_valid (fin_valid),
        .fin_data  (fin_data),
        .fin_ready (fin_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // No status code beyond out of range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[65:64] != 2'd3))
        else $error("ttsi: undefined status code");

    // Invalid results carry a zero value and a zero offset
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[65:64] == ST_INVALID)
            |-> (m_tdata[63:0] == '0 && m_tdata[77:66] == '0))
        else $error("ttsi: invalid result with non-zero fields");

    // Out-of-range results sit at one of the saturation limits
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[65:64] == ST_RANGE)
            |-> (m_tdata[63:0] == OUT_VALUE_WIDTH'(signed'(VALUE_MAX))
                 || m_tdata[63:0] == OUT_VALUE_WIDTH'(signed'(~VALUE_MAX))))
        else $error("ttsi: out-of-range value not saturated");

    // A held byte that is not consumed stays in the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && !in_take) |=> (in_valid && $stable(in_beat)))
        else $error("ttsi: held input byte lost");

endmodule

// File: rtl/core/ttsi_in_reg.sv
// Input beat register for the text-to-integer core.
// Depends on ttsi_pkg for the beat type.
module ttsi_in_reg
    import ttsi_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [S_TDATA_WIDTH-1:0] s_tdata,   // [7:0] char_code
    input  logic                     s_tlast,   // last
    output logic                     in_valid,
    output ttsi_beat_t               in_beat,
    input  logic                     in_take
);

    logic       valid_reg;
    logic       valid_next;
    ttsi_beat_t beat_reg;

    // Refill whenever the held beat is empty or consumed this cycle
    assign s_tready = !valid_reg || in_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on each accepted beat
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            beat_reg.char_code <= s_tdata[CHAR_WIDTH-1:0];
            beat_reg.last      <= s_tlast;
        end
    end

    assign in_valid = valid_reg;
    assign in_beat  = beat_reg;

endmodule

// File: rtl/core/ttsi_parser.sv
// Parse state machine and digit accumulator of the text-to-integer core.
// Depends on ttsi_pkg for types, codes and character decode.
module ttsi_parser
    import ttsi_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [RADIX_WIDTH-1:0] radix,
    input  logic                   in_valid,
    input  ttsi_beat_t             in_beat,
    output logic                   in_take,
    input  logic                   fin_ready,
    output logic                   fin_valid,
    output ttsi_final_t            fin_data
);

    typedef enum logic [4:0] {
        PH_SPACE  = 5'b00001,
        PH_START  = 5'b00010,
        PH_ZERO   = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    phase_t                    phase_reg,   phase_next;
    logic                      neg_reg,     neg_next;
    logic [VALUE_WIDTH-1:0]    acc_reg,     acc_next;
    digit_status_t             dstat_reg,   dstat_next;
    logic [RADIX_WIDTH-1:0]    base_reg,    base_next;
    logic [POSITION_WIDTH-1:0] pos_reg,     pos_next;
    logic [POSITION_WIDTH-1:0] end_pos_reg, end_pos_next;

    logic [CHAR_WIDTH-1:0]     c;
    logic [DIGIT_WIDTH-1:0]    digit;
    logic [POSITION_WIDTH-1:0] pos_inc;
    logic [RADIX_WIDTH-1:0]    start_base;
    logic [RADIX_WIDTH-1:0]    feed_base;
    logic [PROD_WIDTH-1:0]     prod;
    logic [PROD_WIDTH-1:0]     limit;
    logic                      start_now;
    logic                      feed_now;

    assign c       = in_beat.char_code;
    assign digit   = char_digit(c);
    assign pos_inc = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 1'b1;

    // A final byte waits until the result stage can hold it
    assign in_take   = in_valid && (!in_beat.last || fin_ready);
    assign fin_valid = in_take && in_beat.last;

    // Base used when a number starts with a fixed or decimal default
    assign start_base = (radix == BASE_AUTO) ? BASE_DEC : radix;

    // Multiply-add of the next digit and the signed range limit
    assign prod  = PROD_WIDTH'(acc_reg) * PROD_WIDTH'(feed_base) + PROD_WIDTH'(digit);
    assign limit = PROD_WIDTH'(VALUE_MAX) + PROD_WIDTH'(neg_reg);

    // Next parse state for the byte held in the input register
    always_comb begin
        phase_next   = phase_reg;
        neg_next     = neg_reg;
        acc_next     = acc_reg;
        dstat_next   = dstat_reg;
        base_next    = base_reg;
        pos_next     = pos_reg;
        end_pos_next = end_pos_reg;
        start_now    = 1'b0;
        feed_now     = 1'b0;
        feed_base    = base_reg;

        unique case (phase_reg)
            PH_SPACE: begin
                if (char_is_space(c)) begin
                    pos_next = pos_inc;
                end else if (c == CH_MINUS || c == CH_PLUS) begin
                    neg_next   = (c == CH_MINUS);
                    pos_next   = pos_inc;
                    phase_next = PH_START;
                end else begin
                    start_now = 1'b1;
                end
            end
            PH_START: begin
                start_now = 1'b1;
            end
            PH_ZERO: begin
                if (c == CH_LOWER_X || c == CH_UPPER_X) begin
                    base_next  = BASE_HEX;
                    pos_next   = pos_inc;
                    phase_next = PH_DIGITS;
                end else begin
                    feed_base  = (base_reg == BASE_AUTO) ? BASE_OCT : base_reg;
                    base_next  = feed_base;
                    phase_next = PH_DIGITS;
                    feed_now   = 1'b1;
                end
            end
            PH_DIGITS: begin
                feed_now = 1'b1;
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase

        // First byte of the number: leading zero, bad base or first digit
        if (start_now) begin
            if ((radix == BASE_AUTO || radix == BASE_HEX) && c == CH_ZERO) begin
                base_next    = radix;
                pos_next     = pos_inc;
                dstat_next   = DS_OK;
                acc_next     = '0;
                end_pos_next = pos_inc;
                phase_next   = PH_ZERO;
            end else if (start_base < BASE_MIN || start_base > BASE_MAX) begin
                phase_next = PH_DONE;
            end else begin
                base_next  = start_base;
                phase_next = PH_DIGITS;
                feed_now   = 1'b1;
                feed_base  = start_base;
            end
        end

        // Take a digit, or stop on the first byte that is not one
        if (feed_now) begin
            if (feed_base < BASE_MIN || RADIX_WIDTH'(digit) >= feed_base) begin
                phase_next = PH_DONE;
            end else begin
                if (dstat_reg == DS_OVER || prod > limit) begin
                    dstat_next = DS_OVER;
                end else begin
                    dstat_next = DS_OK;
                    acc_next   = prod[VALUE_WIDTH-1:0];
                end
                pos_next     = pos_inc;
                end_pos_next = pos_inc;
            end
        end
    end

    assign fin_data.negative = neg_next;
    assign fin_data.accum    = acc_next;
    assign fin_data.dstat    = dstat_next;
    assign fin_data.end_pos  = end_pos_next;

    // Advance on each taken byte; return to the idle parse after the final one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SPACE;
            neg_reg     <= 1'b0;
            acc_reg     <= '0;
            dstat_reg   <= DS_NONE;
            base_reg    <= BASE_AUTO;
            pos_reg     <= '0;
            end_pos_reg <= '0;
        end else if (in_take) begin
            if (in_beat.last) begin
                phase_reg   <= PH_SPACE;
                neg_reg     <= 1'b0;
                acc_reg     <= '0;
                dstat_reg   <= DS_NONE;
                base_reg    <= BASE_AUTO;
                pos_reg     <= '0;
                end_pos_reg <= '0;
            end else begin
                phase_reg   <= phase_next;
                neg_reg     <= neg_next;
                acc_reg     <= acc_next;
                dstat_reg   <= dstat_next;
                base_reg    <= base_next;
                pos_reg     <= pos_next;
                end_pos_reg <= end_pos_next;
            end
        end
    end

endmodule

// File: rtl/core/ttsi_result.sv
// Result stage of the text-to-integer core: holds the final parse state,
// then forms value, status and offset into the output register. Uses ttsi_pkg.
module ttsi_result
    import ttsi_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     fin_valid,
    input  ttsi_final_t              fin_data,
    output logic                     fin_ready,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [M_TDATA_WIDTH-1:0] m_tdata   // [63:0] value, [65:64] status,
                                               // [77:66] end_offset, [79:78] zero
);

    logic                     hold_valid_reg;
    logic                     hold_valid_next;
    ttsi_final_t              hold_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [M_TDATA_WIDTH-1:0] out_data_reg;
    logic                     out_free;

    logic [VALUE_WIDTH-1:0]   val;
    logic [STATUS_WIDTH-1:0]  status;
    logic [OFFSET_WIDTH-1:0]  offset;

    // Each stage refills when empty or when its beat moves on
    assign out_free  = !out_valid_reg || m_tready;
    assign fin_ready = !hold_valid_reg || out_free;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        out_valid_next  = out_valid_reg;
        if (fin_ready) begin
            hold_valid_next = fin_valid;
        end
        if (out_free) begin
            out_valid_next = hold_valid_reg;
        end
    end

    // Decode the digit progress into the reported result
    always_comb begin
        unique case (hold_reg.dstat)
            DS_OVER: begin
                val    = hold_reg.negative ? ~VALUE_MAX : VALUE_MAX;
                status = ST_RANGE;
                offset = OFFSET_WIDTH'(hold_reg.end_pos);
            end
            DS_OK: begin
                val    = hold_reg.negative ? (~hold_reg.accum + 1'b1) : hold_reg.accum;
                status = ST_OK;
                offset = OFFSET_WIDTH'(hold_reg.end_pos);
            end
            default: begin
                val    = '0;
                status = ST_INVALID;
                offset = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (fin_ready && fin_valid) begin
            hold_reg <= fin_data;
        end
        if (out_free && hold_valid_reg) begin
            out_data_reg <= {{M_PAD_WIDTH{1'b0}}, offset, status,
                             OUT_VALUE_WIDTH'(signed'(val))};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
